FILE: sv/sqe_pkg.sv
// sqe_pkg: shared types and constants for the stack / queue engine.
// Used by stack_queue_engine, stack_queue_scoreboard and stack_queue_engine_test; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sqe_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_W        = 32;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 3'd0,
      OP_POP  = 3'd1,
      OP_SWAP = 3'd2,
      OP_PEEK = 3'd3,
      OP_EMIT = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_SHORT = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SWAP_A,
      S_SWAP_B,
      S_EMIT
   } state_type;

endpackage

`default_nettype wire

FILE: sv/stack_queue_engine.sv
// stack_queue_engine: bounded stack / queue of signed 32-bit entries in a ring buffer.
// Depends on sqe_pkg and sqe_ram.
//
//   channel   dir  handshake          payload
//   req_      in   tvalid / tready    tuser = operation, tdata = push_value
//   rsp_      out  tvalid / tready    tdata = data_value, tuser = has_value,status, tlast
//   csr_      in   we                 wdata = queue_mode
//
// Push, pop, peek: S_IDLE, S_EXEC; swap adds S_SWAP_A, S_SWAP_B; emit all adds S_EMIT
// when not empty, one entry per cycle unless rsp_ stalls, via the single RAM read port.
// Reset (synchronous) empties the store and selects stack mode; RAM contents are kept.
// One item is in work at a time; the result register lets the next item in while
// a result waits, and a stalled rsp_ side holds the engine with no side effects.
`timescale 1ns / 1ps
`default_nettype none

module stack_queue_engine #(
   parameter int DEPTH = sqe_pkg::DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [sqe_pkg::DATA_W-1:0]    req_tdata,   // push_value
   input  wire logic [sqe_pkg::OP_W-1:0]      req_tuser,   // operation
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [sqe_pkg::DATA_W-1:0]    rsp_tdata,   // data_value
   output logic      [sqe_pkg::STATUS_W:0]    rsp_tuser,   // has_value, status[1:0]
   output logic                               rsp_tlast,
   input  wire logic                          csr_we,
   input  wire logic                          csr_wdata    // queue_mode
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   sqe_pkg::state_type  state_ff, state_in;
   sqe_pkg::op_type     op_ff;
   logic [sqe_pkg::DATA_W-1:0] val_ff;
   logic [sqe_pkg::DATA_W-1:0] hold_ff, hold_in;
   logic [AW-1:0]       front_ff, front_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                mode_ff;

   logic                rsp_valid_ff;
   logic [sqe_pkg::DATA_W-1:0] rsp_data_ff;
   logic                rsp_has_ff;
   sqe_pkg::status_type rsp_status_ff;
   logic                rsp_last_ff;

   logic                load_rsp;
   logic [sqe_pkg::DATA_W-1:0] r_data;
   logic                r_has;
   sqe_pkg::status_type r_status;
   logic                r_last;

   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [sqe_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

   logic                out_free, is_empty, is_full, is_short, emit_last;
   logic [AW-1:0]       front_inc, front_dec, slot_tail, slot_next;
   logic [CW-1:0]       idx_next;

   function automatic logic [AW-1:0] wrap(input logic [SW-1:0] sum);
      logic [SW-1:0] r;
      r = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
      return r[AW-1:0];
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_short  = (count_ff < CW'(2));
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign idx_next  = idx_ff + CW'(1);
   assign emit_last = (idx_next == count_ff);
   assign slot_tail = wrap(SW'(front_ff) + SW'(count_ff));
   assign slot_next = wrap(SW'(front_ff) + SW'(idx_next));

   sqe_ram #(
      .WIDTH (sqe_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sqe_pkg::S_IDLE: begin
            if (req_tvalid) state_in = sqe_pkg::S_EXEC;
         end
         sqe_pkg::S_EXEC: begin
            case (op_ff)
               sqe_pkg::OP_SWAP: begin
                  if (!is_short) state_in = sqe_pkg::S_SWAP_A;
                  else if (out_free) state_in = sqe_pkg::S_IDLE;
               end
               sqe_pkg::OP_EMIT: begin
                  if (!is_empty) state_in = sqe_pkg::S_EMIT;
                  else if (out_free) state_in = sqe_pkg::S_IDLE;
               end
               default: begin
                  if (out_free) state_in = sqe_pkg::S_IDLE;
               end
            endcase
         end
         sqe_pkg::S_SWAP_A: state_in = sqe_pkg::S_SWAP_B;
         sqe_pkg::S_SWAP_B: begin
            if (out_free) state_in = sqe_pkg::S_IDLE;
         end
         sqe_pkg::S_EMIT: begin
            if (out_free && emit_last) state_in = sqe_pkg::S_IDLE;
         end
         default: state_in = sqe_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == sqe_pkg::S_IDLE);
      ram_re     = 1'b0;
      ram_raddr  = front_ff;
      ram_we     = 1'b0;
      ram_waddr  = front_ff;
      ram_wdata  = val_ff;
      load_rsp   = 1'b0;
      r_data     = '0;
      r_has      = 1'b0;
      r_status   = sqe_pkg::ST_OK;
      r_last     = 1'b1;
      front_in   = front_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      hold_in    = hold_ff;
      case (state_ff)
         sqe_pkg::S_IDLE: begin
            ram_re = req_tvalid;
         end
         sqe_pkg::S_EXEC: begin
            case (op_ff)
               sqe_pkg::OP_PUSH: begin
                  if (out_free) begin
                     load_rsp = 1'b1;
                     if (is_full) begin
                        r_status = sqe_pkg::ST_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (mode_ff) begin
                           ram_waddr = slot_tail;
                        end else begin
                           ram_waddr = front_dec;
                           front_in  = front_dec;
                        end
                     end
                  end
               end
               sqe_pkg::OP_POP: begin
                  if (out_free) begin
                     load_rsp = 1'b1;
                     if (is_empty) begin
                        r_status = sqe_pkg::ST_EMPTY;
                     end else begin
                        front_in = front_inc;
                        count_in = count_ff - CW'(1);
                     end
                  end
               end
               sqe_pkg::OP_SWAP: begin
                  if (is_short) begin
                     load_rsp = out_free;
                     r_status = sqe_pkg::ST_SHORT;
                  end else begin
                     hold_in   = ram_rdata;
                     ram_re    = 1'b1;
                     ram_raddr = front_inc;
                  end
               end
               sqe_pkg::OP_PEEK: begin
                  load_rsp = out_free;
                  if (is_empty) begin
                     r_status = sqe_pkg::ST_EMPTY;
                  end else begin
                     r_data = ram_rdata;
                     r_has  = 1'b1;
                  end
               end
               sqe_pkg::OP_EMIT: begin
                  if (is_empty) load_rsp = out_free;
                  else idx_in = '0;
               end
               default: begin
                  load_rsp = out_free;
               end
            endcase
         end
         sqe_pkg::S_SWAP_A: begin
            ram_we    = 1'b1;
            ram_waddr = front_ff;
            ram_wdata = ram_rdata;
         end
         sqe_pkg::S_SWAP_B: begin
            if (out_free) begin
               ram_we    = 1'b1;
               ram_waddr = front_inc;
               ram_wdata = hold_ff;
               load_rsp  = 1'b1;
            end
         end
         sqe_pkg::S_EMIT: begin
            if (out_free) begin
               load_rsp = 1'b1;
               r_data   = ram_rdata;
               r_has    = 1'b1;
               r_last   = emit_last;
               if (!emit_last) begin
                  ram_re    = 1'b1;
                  ram_raddr = slot_next;
                  idx_in    = idx_next;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sqe_pkg::S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         if (csr_we) mode_ff <= csr_wdata;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff  <= sqe_pkg::op_type'(req_tuser);
         val_ff <= req_tdata;
      end
      idx_ff  <= idx_in;
      hold_ff <= hold_in;
      if (load_rsp) begin
         rsp_data_ff   <= r_data;
         rsp_has_ff    <= r_has;
         rsp_status_ff <= r_status;
         rsp_last_ff   <= r_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_has_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sqe_pkg::S_IDLE) |-> !ram_we)
      else $error("RAM write while idle");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sqe_pkg::S_EXEC && op_ff == sqe_pkg::OP_POP && out_free && !is_empty)
      |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("pop did not shrink the store");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sqe_pkg::S_EMIT) |-> (idx_ff < count_ff))
      else $error("emit index past the last entry");
`endif

endmodule

`default_nettype wire

FILE: sv/sqe_ram.sv
// sqe_ram: generic single-write, single-read synchronous RAM with registered read.
// Standalone; instantiated by stack_queue_engine.
`timescale 1ns / 1ps
`default_nettype none

module sqe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: tb/stack_queue_scoreboard.sv
// stack_queue_scoreboard: watches the req_, rsp_ and csr_ channels of the stack / queue
// engine, keeps its own copy of the ring store, predicts every reply and compares.
// Depends on sqe_pkg.
`timescale 1ns / 1ps

module stack_queue_scoreboard #(
   parameter int DEPTH = sqe_pkg::DEPTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic [sqe_pkg::DATA_W-1:0]     req_tdata,   // push_value
   input  wire logic [sqe_pkg::OP_W-1:0]       req_tuser,   // operation
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [sqe_pkg::DATA_W-1:0]     rsp_tdata,   // data_value
   input  wire logic [sqe_pkg::STATUS_W:0]     rsp_tuser,   // has_value, status[1:0]
   input  wire logic                           rsp_tlast,
   input  wire logic                           csr_we,
   input  wire logic                           csr_wdata,   // queue_mode
   output int                                  mismatches,
   output int                                  outstanding,
   output int                                  replies_checked,
   output int                                  corner_replies
);

   localparam int PTR_W = $clog2(DEPTH);

   typedef struct {
      logic [sqe_pkg::DATA_W-1:0] data_value;
      logic                       has_value;
      sqe_pkg::status_type        status;
      logic                       last;
   } reply_type;

   reply_type                  pending_replies[$];
   logic [sqe_pkg::DATA_W-1:0] slot_data[DEPTH];
   logic [PTR_W-1:0]           head;
   logic [PTR_W:0]             fill;
   logic                       queue_mode;

   function automatic int slot_at(input int offset);
      return (int'(head) + offset) % DEPTH;
   endfunction

   task automatic queue_reply(input logic [sqe_pkg::DATA_W-1:0] data, input logic has,
                              input sqe_pkg::status_type status, input logic last);
      reply_type r;
      r.data_value = data;
      r.has_value  = has;
      r.status     = status;
      r.last       = last;
      pending_replies.push_back(r);
   endtask

   task automatic apply_operation(input logic [sqe_pkg::OP_W-1:0] code,
                                  input logic [sqe_pkg::DATA_W-1:0] value);
      logic [sqe_pkg::DATA_W-1:0] held;
      int                         a;
      int                         b;
      case (code)
         sqe_pkg::OP_PUSH: begin
            if (fill >= DEPTH) begin
               queue_reply('0, 1'b0, sqe_pkg::ST_FULL, 1'b1);
            end else begin
               if (queue_mode) begin
                  slot_data[slot_at(int'(fill))] = value;
               end else begin
                  head = PTR_W'((int'(head) + DEPTH - 1) % DEPTH);
                  slot_data[head] = value;
               end
               fill = fill + 1'b1;
               queue_reply('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
            end
         end
         sqe_pkg::OP_POP: begin
            if (fill == 0) begin
               queue_reply('0, 1'b0, sqe_pkg::ST_EMPTY, 1'b1);
            end else begin
               head = PTR_W'(slot_at(1));
               fill = fill - 1'b1;
               queue_reply('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
            end
         end
         sqe_pkg::OP_SWAP: begin
            if (fill < 2) begin
               queue_reply('0, 1'b0, sqe_pkg::ST_SHORT, 1'b1);
            end else begin
               a = slot_at(0);
               b = slot_at(1);
               held         = slot_data[a];
               slot_data[a] = slot_data[b];
               slot_data[b] = held;
               queue_reply('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
            end
         end
         sqe_pkg::OP_PEEK: begin
            if (fill == 0) begin
               queue_reply('0, 1'b0, sqe_pkg::ST_EMPTY, 1'b1);
            end else begin
               queue_reply(slot_data[slot_at(0)], 1'b1, sqe_pkg::ST_OK, 1'b1);
            end
         end
         sqe_pkg::OP_EMIT: begin
            if (fill == 0) begin
               queue_reply('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
            end else begin
               for (int i = 0; i < int'(fill); i++)
                  queue_reply(slot_data[slot_at(i)], 1'b1, sqe_pkg::ST_OK,
                              i == int'(fill) - 1);
            end
         end
         default: begin
            queue_reply('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
         end
      endcase
   endtask

   task automatic report(input string field, input logic [sqe_pkg::DATA_W-1:0] want,
                         input logic [sqe_pkg::DATA_W-1:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endtask

   task automatic check_reply();
      reply_type r;
      replies_checked++;
      if (pending_replies.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected reply, expected none, actual data %h user %b last %b",
                  $time, rsp_tdata, rsp_tuser, rsp_tlast);
      end else begin
         r = pending_replies.pop_front();
         if (r.status != sqe_pkg::ST_OK)
            corner_replies++;
         if (rsp_tdata !== r.data_value)
            report("data_value", r.data_value, rsp_tdata);
         if (rsp_tuser[0] !== r.has_value)
            report("has_value", sqe_pkg::DATA_W'(r.has_value),
                   sqe_pkg::DATA_W'(rsp_tuser[0]));
         if (rsp_tuser[sqe_pkg::STATUS_W:1] !== r.status)
            report("status", sqe_pkg::DATA_W'(r.status),
                   sqe_pkg::DATA_W'(rsp_tuser[sqe_pkg::STATUS_W:1]));
         if (rsp_tlast !== r.last)
            report("last", sqe_pkg::DATA_W'(r.last), sqe_pkg::DATA_W'(rsp_tlast));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pending_replies.delete();
         head       = '0;
         fill       = '0;
         queue_mode = 1'b0;
      end else begin
         if (csr_we)
            queue_mode = csr_wdata;
         if (rsp_tvalid && rsp_tready)
            check_reply();
         if (req_tvalid && req_tready)
            apply_operation(req_tuser, req_tdata);
      end
      outstanding = pending_replies.size();
   end

endmodule

FILE: tb/stack_queue_engine_test.sv
// stack_queue_engine_test: clock, reset and item stimulus for stack_queue_engine, with
// random idling on both channels and a long rsp_ hold-off; verdict from the scoreboard.
// Depends on sqe_pkg, stack_queue_engine and stack_queue_scoreboard.
`timescale 1ns / 1ps

module stack_queue_engine_test;

   localparam int DEPTH      = sqe_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_CAP  = 250000;
   localparam int HOLD_OFF   = 200;
   localparam int DRAIN_WAIT = 20;

   // operation codes the block does not use
   localparam logic [sqe_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [sqe_pkg::OP_W-1:0] OP_SPARE_MID   = 3'd6;
   localparam logic [sqe_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   localparam logic [sqe_pkg::DATA_W-1:0] MOST_NEG = 32'h8000_0000;
   localparam logic [sqe_pkg::DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;
   localparam logic [sqe_pkg::DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [sqe_pkg::DATA_W-1:0]   req_tdata  = '0;    // push_value
   logic [sqe_pkg::OP_W-1:0]     req_tuser  = '0;    // operation
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [sqe_pkg::DATA_W-1:0]   rsp_tdata;          // data_value
   logic [sqe_pkg::STATUS_W:0]   rsp_tuser;          // has_value, status[1:0]
   logic                         rsp_tlast;
   logic                         csr_we     = 1'b0;
   logic                         csr_wdata  = 1'b0;  // queue_mode

   int mismatches;
   int outstanding;
   int replies_checked;
   int corner_replies;

   int tx_idle_pct = 22;
   int rx_idle_pct = 64;
   int stall_asks  = 0;
   int stall_seen  = 0;
   int stall_left  = 0;
   int cycle_count = 0;
   int items_sent  = 0;
   int level       = 0;

   stack_queue_engine #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   stack_queue_scoreboard #(.DEPTH(DEPTH)) scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .replies_checked (replies_checked),
      .corner_replies  (corner_replies)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count,
                  outstanding);
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random back-pressure, plus a long hold-off on request
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_asks != stall_seen) begin
         stall_seen <= stall_asks;
         stall_left <= HOLD_OFF;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   function automatic logic [sqe_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(15))
         0:       return MOST_NEG;
         1:       return MOST_POS;
         2:       return '0;
         3:       return ALL_ONES;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_item(input logic [sqe_pkg::OP_W-1:0] code,
                            input logic [sqe_pkg::DATA_W-1:0] value);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
      if (code == sqe_pkg::OP_PUSH && level < DEPTH)
         level++;
      else if (code == sqe_pkg::OP_POP && level > 0)
         level--;
   endtask

   task automatic send_mixed(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 40)
            send_item(sqe_pkg::OP_PUSH, pick_value());
         else if (pick < 58)
            send_item(sqe_pkg::OP_POP, $urandom());
         else if (pick < 70)
            send_item(sqe_pkg::OP_SWAP, $urandom());
         else if (pick < 80)
            send_item(sqe_pkg::OP_PEEK, $urandom());
         else if (pick < 88)
            send_item(sqe_pkg::OP_EMIT, $urandom());
         else
            send_item(sqe_pkg::OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
                      $urandom());
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int top_up;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: stack mode, empty and short cases, extremes, spare codes
      write_mode(1'b0);
      send_item(sqe_pkg::OP_POP, ALL_ONES);
      send_item(sqe_pkg::OP_PEEK, '0);
      send_item(sqe_pkg::OP_SWAP, '0);
      send_item(sqe_pkg::OP_EMIT, '0);
      send_item(sqe_pkg::OP_PUSH, MOST_POS);
      send_item(sqe_pkg::OP_SWAP, '0);
      send_item(sqe_pkg::OP_PUSH, MOST_NEG);
      send_item(sqe_pkg::OP_PEEK, '0);
      send_item(sqe_pkg::OP_SWAP, '0);
      send_item(sqe_pkg::OP_PEEK, '0);
      send_item(sqe_pkg::OP_EMIT, '0);
      send_item(OP_SPARE_FIRST, ALL_ONES);
      send_item(OP_SPARE_MID, MOST_POS);
      send_item(OP_SPARE_LAST, MOST_NEG);
      send_item(sqe_pkg::OP_POP, '0);
      send_item(sqe_pkg::OP_POP, '0);
      send_item(sqe_pkg::OP_POP, '0);

      // directed: queue mode
      write_mode(1'b1);
      send_item(sqe_pkg::OP_PUSH, ALL_ONES);
      send_item(sqe_pkg::OP_PUSH, '0);
      send_item(sqe_pkg::OP_PUSH, 32'd1);
      send_item(sqe_pkg::OP_EMIT, '0);
      send_item(sqe_pkg::OP_SWAP, '0);
      send_item(sqe_pkg::OP_PEEK, '0);
      send_item(sqe_pkg::OP_POP, '0);
      send_item(sqe_pkg::OP_EMIT, '0);

      // random, stack mode
      write_mode(1'b0);
      send_mixed(30);

      // random, queue mode, idling swapped
      write_mode(1'b1);
      tx_idle_pct = 64;
      rx_idle_pct = 22;
      send_mixed(30);

      // no idling: long receiver hold-off while filling past full
      write_mode(1'b0);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      stall_asks <= stall_asks + 1;
      top_up = DEPTH - level + 2;
      repeat (top_up)
         send_item(sqe_pkg::OP_PUSH, pick_value());
      send_item(sqe_pkg::OP_EMIT, '0);
      send_item(sqe_pkg::OP_SWAP, '0);
      send_item(sqe_pkg::OP_PEEK, '0);
      send_mixed(15);
      send_item(sqe_pkg::OP_EMIT, '0);

      settle();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d items in stack and queue mode, checked %0d replies,", items_sent,
               replies_checked);
      $display("%0d of them flagged an empty, short or full store.", corner_replies);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: stack_queue_engine.f
sv/sqe_pkg.sv
sv/sqe_ram.sv
sv/stack_queue_engine.sv
tb/stack_queue_scoreboard.sv
tb/stack_queue_engine_test.sv
